// ----- design/hb64_pkg.sv -----
package hb64_pkg;

  localparam int HB64_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] hex_char;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic [7:0] b64_char;
    logic       last_out;
    logic       bad_digit;
  } out_word_t;

  // One job is the output of one group of three digits, or of the leftover at the end of a stream: one or two sextets.
  typedef struct packed {
    logic [5:0] sextet0;
    logic [5:0] sextet1;
    logic       two;
    logic       last;
    logic       err;
  } job_t;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  // Returns {ok, nibble}; a non-hex character gives nibble zero.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
      return {1'b1, v[3:0]};
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      v = c - CH_LOWER_A + HEX_TEN;
      return {1'b1, v[3:0]};
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      v = c - CH_UPPER_A + HEX_TEN;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic [7:0] b64_encode(input logic [5:0] s);
    logic [7:0] v;
    v = {2'b00, s};
    if (v < 8'd26) begin
      return CH_UPPER_A + v;
    end else if (v < 8'd52) begin
      return CH_LOWER_A + (v - 8'd26);
    end else if (v < 8'd62) begin
      return CH_ZERO + (v - 8'd52);
    end else if (v == 8'd62) begin
      return CH_PLUS;
    end
    return CH_SLASH;
  endfunction

endpackage

// ----- design/hb64_front.sv -----
module hb64_front
  import hb64_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     push,
  output job_t     push_job,
  input  logic     push_ready
);

  logic [7:0] nibble_store, nibble_store_next;
  logic [1:0] nibble_count, nibble_count_next;
  logic       error_seen, error_seen_next;

  logic [4:0]  dec;
  logic [1:0]  cnt_sat;
  logic [1:0]  cnt_new;
  logic [11:0] bits;
  logic        err;
  logic        emit;
  logic        take;

  assign in_ready = push_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    dec     = hex_decode(in_data.hex_char);
    cnt_sat = (nibble_count == 2'd3) ? 2'd2 : nibble_count;
    cnt_new = cnt_sat + 2'd1;
    bits    = {nibble_store, dec[3:0]};
    err     = error_seen | ~dec[4];
    emit    = 1'b0;

    push_job.sextet0 = bits[11:6];
    push_job.sextet1 = bits[5:0];
    push_job.two     = 1'b1;
    push_job.last    = in_data.last_char;
    push_job.err     = err;

    nibble_store_next = bits[7:0];
    nibble_count_next = cnt_new;
    error_seen_next   = err;

    if (cnt_new == 2'd3) begin
      emit              = 1'b1;
      nibble_store_next = 8'd0;
      nibble_count_next = 2'd0;
    end else if (in_data.last_char) begin
      emit = 1'b1;
      if (cnt_new == 2'd1) begin
        push_job.sextet0 = {bits[3:0], 2'b00};
        push_job.two     = 1'b0;
      end else begin
        push_job.sextet0 = bits[7:2];
        push_job.sextet1 = {bits[1:0], 4'b0000};
      end
    end

    if (in_data.last_char) begin
      nibble_store_next = 8'd0;
      nibble_count_next = 2'd0;
      error_seen_next   = 1'b0;
    end
  end

  assign push = take && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_store <= 8'd0;
      nibble_count <= 2'd0;
      error_seen   <= 1'b0;
    end else if (take) begin
      nibble_store <= nibble_store_next;
      nibble_count <= nibble_count_next;
      error_seen   <= error_seen_next;
    end
  end

endmodule

// ----- design/hb64_queue.sv -----
module hb64_queue
  import hb64_pkg::*;
#(
  parameter int DEPTH = HB64_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/hb64_back.sv -----
module hb64_back
  import hb64_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  input  job_t      job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  // Phase is set once the first of a two-character job has gone out.
  logic      phase;
  logic      load;
  logic      second;
  out_word_t word_next;

  assign load   = job_valid && (!out_valid || out_ready);
  assign second = job.two && phase;
  assign pop    = load && (!job.two || phase);

  always_comb begin
    word_next.b64_char  = b64_encode(second ? job.sextet1 : job.sextet0);
    word_next.last_out  = (job.two && !phase) ? 1'b0 : job.last;
    word_next.bad_digit = job.err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= job.two && !phase;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= word_next;
    end
  end

endmodule

// ----- design/hex_to_base64_stream_core.sv -----
// Channel  Handshake             Word        Fields
// in       in_valid / in_ready   in_word_t   hex_char, last_char
// out      out_valid / out_ready out_word_t  b64_char, last_out, bad_digit
//
// One hex digit is taken per cycle while the job queue has room.
// One base64 character leaves the output register per cycle while out_ready
// is high, so a job of two characters holds the output stage until both have
// left; three digits give two characters, so a steady stream runs at one digit a cycle.
// Reset (rst, synchronous) clears the nibble state, the queue and the output register.
// A stalled output fills the queue, and only then does in_ready fall.
module hex_to_base64_stream_core
  import hb64_pkg::*;
#(
  parameter int QUEUE_DEPTH = HB64_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  // The front collects nibbles and turns each completed group, or the
  // leftover at the end of a stream, into a job of one or two sextets.
  logic push;
  job_t push_job;
  logic push_ready;

  // The back drains jobs one character per cycle into the output register while out_ready is high.
  logic pop;
  logic pop_valid;
  job_t head;

  hb64_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  // The queue lets the front keep accepting digits while the back waits on
  // a stalled consumer.
  hb64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .head       (head)
  );

  hb64_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (pop_valid),
    .job       (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- design/hb64_checker.sv -----
module hb64_checker
  import hb64_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  logic legal_char;

  assign legal_char =
      (out_data.b64_char >= CH_UPPER_A && out_data.b64_char <= 8'h5a) ||
      (out_data.b64_char >= CH_LOWER_A && out_data.b64_char <= 8'h7a) ||
      (out_data.b64_char >= CH_ZERO && out_data.b64_char <= CH_NINE) ||
      (out_data.b64_char == CH_PLUS) || (out_data.b64_char == CH_SLASH);

  // An offered input word waits unchanged until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input word changed while waiting");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_out_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> legal_char)
    else $error("output character outside the base64 alphabet");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_reset_in: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind hex_to_base64_stream_core hb64_checker u_hb64_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- verif/tb_hex_to_base64_stream_core.sv -----
module tb_hex_to_base64_stream_core;
  import hb64_pkg::*;

  // Standard base64 alphabet and the hex digits the stimulus picks from,
  // packed with the first character in the top byte.
  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [8*22-1:0] HEX_DIGITS = "0123456789abcdefABCDEF";
  // The watchdog gives up after this many cycles in which no word moves on
  // either channel. The longest legal quiet spell is the receiver hold-off.
  localparam int IDLE_LIMIT     = 2000;
  localparam int LONG_HOLD      = 200;
  localparam int HOLD_AFTER     = 300;
  localparam int RANDOM_DIGITS  = 1650;
  localparam int DRAIN_CYCLES   = 20;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // Digits still to be offered, and characters the block still owes us.
  in_word_t  digit_q[$];
  out_word_t b64_expect_q[$];

  // Private copy of the converter state: pending nibbles, how many, and the
  // sticky bad-digit flag of the current stream.
  logic [7:0] held_nibs = '0;
  logic [1:0] held_cnt = '0;
  logic       stream_bad = 1'b0;

  // Handshake flags from the last rising edge, read by the falling-edge drivers.
  logic in_acc = 1'b0;
  logic out_acc = 1'b0;

  int  send_gap = 0;
  int  send_burst = 0;
  int  recv_wait = 0;
  int  recv_burst = 0;
  int  chars_seen = 0;
  int  idle_cycles = 0;
  bit  hold_done = 1'b0;
  bit  failed = 1'b0;

  hex_to_base64_stream_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Waits between words are drawn at random, but now and then a burst of
  // back-to-back words follows so that full-rate stretches are covered too.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(20, 60);
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic void push_digit(input logic [7:0] c, input logic last);
    in_word_t w;
    w.hex_char = c;
    w.last_char = last;
    digit_q.push_back(w);
  endfunction

  function automatic void push_stream(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_digit(s[i], i == s.len() - 1);
    end
  endfunction

  function automatic void emit_char(input logic [5:0] sextet, input logic last,
                                    input logic err);
    out_word_t w;
    w.b64_char  = B64_ALPHABET[8*(63 - sextet) +: 8];
    w.last_out  = last;
    w.bad_digit = err;
    b64_expect_q.push_back(w);
  endfunction

  // Folds one accepted digit into the private state and queues the base64
  // characters it produces: two per completed group of three digits, and on
  // the last digit of a stream the leftover, zero-filled on the right.
  function automatic void encode_digit(input in_word_t w);
    logic [3:0]  nib;
    logic        good;
    logic [11:0] acc;
    logic [11:0] tail;
    int          cnt;
    good = 1'b1;
    nib  = 4'd0;
    if (w.hex_char >= CH_ZERO && w.hex_char <= CH_NINE) begin
      nib = 4'(w.hex_char - CH_ZERO);
    end else if (w.hex_char >= CH_LOWER_A && w.hex_char <= CH_LOWER_F) begin
      nib = 4'(w.hex_char - CH_LOWER_A + 8'd10);
    end else if (w.hex_char >= CH_UPPER_A && w.hex_char <= CH_UPPER_F) begin
      nib = 4'(w.hex_char - CH_UPPER_A + 8'd10);
    end else begin
      good = 1'b0;
    end
    // A count of three never sits in the state; anything above two saturates.
    cnt = (held_cnt > 2'd2) ? 2 : int'(held_cnt);
    if (!good) begin
      stream_bad = 1'b1;
    end
    acc = {held_nibs, nib};
    cnt++;
    if (cnt == 3) begin
      emit_char(acc[11:6], 1'b0, stream_bad);
      emit_char(acc[5:0], w.last_char, stream_bad);
      acc = '0;
      cnt = 0;
    end else if (w.last_char) begin
      if (cnt == 1) begin
        emit_char({acc[3:0], 2'b00}, 1'b1, stream_bad);
      end else begin
        tail = {acc[7:0], 4'b0000};
        emit_char(tail[11:6], 1'b0, stream_bad);
        emit_char(tail[5:0], 1'b1, stream_bad);
      end
    end
    // The end of a stream clears everything, including the error flag.
    if (w.last_char) begin
      held_nibs  = '0;
      held_cnt   = '0;
      stream_bad = 1'b0;
    end else begin
      held_nibs = acc[7:0];
      held_cnt  = 2'(cnt);
    end
  endfunction

  function automatic void check_char(input out_word_t got);
    out_word_t want;
    if (b64_expect_q.size() == 0) begin
      $error("unexpected word: b64_char %h last_out %b bad_digit %b",
             got.b64_char, got.last_out, got.bad_digit);
      failed = 1'b1;
      return;
    end
    want = b64_expect_q.pop_front();
    if (got.b64_char !== want.b64_char) begin
      $error("b64_char expected %h actual %h", want.b64_char, got.b64_char);
      failed = 1'b1;
    end
    if (got.last_out !== want.last_out) begin
      $error("last_out expected %b actual %b", want.last_out, got.last_out);
      failed = 1'b1;
    end
    if (got.bad_digit !== want.bad_digit) begin
      $error("bad_digit expected %b actual %b", want.bad_digit, got.bad_digit);
      failed = 1'b1;
    end
  endfunction

  // Sender. A word stays on the bus until the rising edge that takes it; only
  // then does the driver draw the next gap or move on to the next digit.
  always @(negedge clk) begin
    if (!rst && !(in_valid && !in_acc)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (digit_q.size() > 0) begin
        in_data  <= digit_q.pop_front();
        in_valid <= 1'b1;
        send_gap = draw_gap(send_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. After each word it draws a stall. Once, a few hundred characters
  // in, it holds off for a long stretch so the internal queue fills up and
  // in_ready has to drop while the sender keeps offering digits.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_acc) begin
        recv_wait = draw_gap(recv_burst);
        if (!hold_done && chars_seen >= HOLD_AFTER) begin
          recv_wait = LONG_HOLD;
          hold_done = 1'b1;
        end
      end
      if (recv_wait > 0) begin
        out_ready <= 1'b0;
        recv_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor. The output word is checked before the input word of the same
  // edge is predicted, so a character that shows up with nothing owed is
  // never hidden by a prediction made in the same cycle.
  always @(posedge clk) begin
    in_acc  <= !rst && in_valid && in_ready;
    out_acc <= !rst && out_valid && out_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        check_char(out_data);
        chars_seen++;
      end
      if (in_valid && in_ready) begin
        encode_digit(in_data);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int          sent;
    int          len;
    bit          noisy;
    logic [7:0]  c;
    // Directed part. Full groups at both extremes of the alphabet, single and
    // double leftovers, mixed-case digits, every neighbor just outside the
    // three digit ranges, the all-zero and all-one bytes, and a clean stream
    // right after a bad one to see the error flag cleared.
    push_stream("fff");
    push_stream("000");
    push_stream("0");
    push_stream("F");
    push_stream("ff");
    push_stream("9aA");
    push_stream("/@G`g:");
    push_digit(8'h00, 1'b0);
    push_digit(8'hff, 1'b1);
    push_stream("1");

    // Random streams, mostly short so every leftover length comes up often.
    // Most are clean hex; the rest carry stray bytes of any value.
    sent = 0;
    while (sent < RANDOM_DIGITS) begin
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      noisy = ($urandom_range(0, 9) < 3);
      for (int i = 0; i < len; i++) begin
        if (noisy && $urandom_range(0, 7) == 0) begin
          c = 8'($urandom_range(0, 255));
        end else begin
          c = HEX_DIGITS[8*(21 - $urandom_range(0, 21)) +: 8];
        end
        push_digit(c, i == len - 1);
      end
      sent += len;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (digit_q.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (b64_expect_q.size() != 0) begin
      @(posedge clk);
    end
    // A drain period to catch any character the block should not send.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && b64_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
